// File: rtl/gap_pkg.sv
// Shared types, widths and register codes of the gradient amplitude projection.
package gap_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int LIMIT_BITS  = 23;
  localparam int SCALE_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_AXES    = 3;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS;
  localparam int ROOT_BITS   = SQ_BITS / 2;
  localparam int QUO_BITS    = SAMPLE_BITS;
  localparam int PROD_BITS   = SAMPLE_BITS + LIMIT_BITS;
  localparam int PIN_BITS    = SAMPLE_BITS + SCALE_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CLIP_LIMIT    = 2'd0,
    CFG_PER_AXIS_MODE = 2'd1,
    CFG_AXIS_COUNT    = 2'd2,
    CFG_PIN_SCALE     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_axis0;
    logic signed [SAMPLE_BITS-1:0] sample_axis1;
    logic signed [SAMPLE_BITS-1:0] sample_axis2;
    logic [NUM_AXES-1:0]           pin_mask;
    logic signed [SAMPLE_BITS-1:0] pin_axis0;
    logic signed [SAMPLE_BITS-1:0] pin_axis1;
    logic signed [SAMPLE_BITS-1:0] pin_axis2;
    logic                          end_in;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] result_axis0;
    logic signed [SAMPLE_BITS-1:0] result_axis1;
    logic signed [SAMPLE_BITS-1:0] result_axis2;
    logic                          was_clipped;
    logic                          end_out;
  } result_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] x;
    logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] pinv;
    logic [NUM_AXES-1:0]                  pmask;
    logic [NUM_AXES-1:0]                  act;
    logic                                 mode;
    logic                                 scale;
    logic                                 end_flag;
  } side_t;

endpackage

// File: rtl/gradient_amplitude_projection_top.sv
// Pipelined amplitude projection of one multi-axis gradient word.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------
//  sample   | sample_valid/_stall    | sample (sample_t)
//  result   | result_valid/_stall    | result (result_t)
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One word enters per cycle while the result is not stalled; the pipeline holds 24
// square-root stages and 24 divide stages, one result bit each.
// Synchronous reset clears the valid bits and loads register defaults.
// A stalled result freezes every stage; sample_stall follows it.
module gradient_amplitude_projection_top import gap_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  sample_t                  sample,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_t                  result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef struct packed {
    logic                                valid;
    side_t                               side;
    logic [SQ_BITS-1:0]                  v;
    logic [ROOT_BITS+1:0]                rem;
    logic [ROOT_BITS-1:0]                root;
    logic [NUM_AXES-1:0][PROD_BITS-1:0]  prodl;
  } sqs_t;

  typedef struct packed {
    logic                                valid;
    side_t                               side;
    logic [ROOT_BITS-1:0]                norm;
    logic [NUM_AXES-1:0][ROOT_BITS-1:0]  r;
    logic [NUM_AXES-1:0][QUO_BITS-1:0]   low;
    logic [NUM_AXES-1:0][QUO_BITS-1:0]   q;
  } dvs_t;

  logic [LIMIT_BITS-1:0] clip_limit;
  logic                  per_axis_mode;
  logic [1:0]            axis_count;
  logic [SCALE_BITS-1:0] pin_scale;

  logic en;

  logic                                   s1_valid;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   s1_x;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   s1_pinraw;
  logic [NUM_AXES-1:0][SQ_BITS-1:0]       s1_sq;
  logic [NUM_AXES-1:0][PROD_BITS-1:0]     s1_prodl;
  logic [NUM_AXES-1:0][PIN_BITS-1:0]      s1_pprod;
  logic [2*LIMIT_BITS-1:0]                s1_limsq;
  logic [NUM_AXES-1:0]                    s1_act;
  logic [NUM_AXES-1:0]                    s1_pmask;
  logic                                   s1_mode;
  logic                                   s1_end;

  sqs_t sq_st [0:ROOT_BITS];
  dvs_t dv_st [0:QUO_BITS];

  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] in_x;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] in_p;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] in_mag;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] in_pmag;
  logic [NUM_AXES-1:0]                  in_act;

  sqs_t    sq_init;
  dvs_t    dv_init;
  result_t res_next;

  function automatic sqs_t sqrt_step(sqs_t a);
    sqs_t                 o;
    logic [ROOT_BITS+3:0] rw;
    logic [ROOT_BITS+3:0] t;
    o  = a;
    rw = {a.rem, a.v[SQ_BITS-1 -: 2]};
    t  = {2'b00, a.root, 2'b01};
    if (rw >= t) begin
      rw     = rw - t;
      o.root = {a.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      o.root = {a.root[ROOT_BITS-2:0], 1'b0};
    end
    o.rem = rw[ROOT_BITS+1:0];
    o.v   = {a.v[SQ_BITS-3:0], 2'b00};
    return o;
  endfunction

  function automatic dvs_t div_step(dvs_t a);
    dvs_t               o;
    logic [ROOT_BITS:0] r2;
    o = a;
    for (int k = 0; k < NUM_AXES; k++) begin
      r2 = {a.r[k], a.low[k][QUO_BITS-1]};
      if (r2 >= {1'b0, a.norm}) begin
        r2      = r2 - {1'b0, a.norm};
        o.q[k]  = {a.q[k][QUO_BITS-2:0], 1'b1};
      end else begin
        o.q[k]  = {a.q[k][QUO_BITS-2:0], 1'b0};
      end
      o.r[k]   = r2[ROOT_BITS-1:0];
      o.low[k] = {a.low[k][QUO_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  assign cfg_ready    = 1'b1;
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_limit    <= {LIMIT_BITS{1'b1}};
      per_axis_mode <= 1'b0;
      axis_count    <= 2'd3;
      pin_scale     <= SCALE_BITS'(1 << FRAC_BITS);
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CLIP_LIMIT:    clip_limit    <= cfg_data[LIMIT_BITS-1:0];
        CFG_PER_AXIS_MODE: per_axis_mode <= cfg_data[0];
        CFG_AXIS_COUNT:    axis_count    <= cfg_data[1:0];
        CFG_PIN_SCALE:     pin_scale     <= cfg_data[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_x[0] = sample.sample_axis0;
    in_x[1] = sample.sample_axis1;
    in_x[2] = sample.sample_axis2;
    in_p[0] = sample.pin_axis0;
    in_p[1] = sample.pin_axis1;
    in_p[2] = sample.pin_axis2;
    for (int k = 0; k < NUM_AXES; k++) begin
      in_act[k]  = (k < axis_count);
      in_mag[k]  = (!in_act[k]) ? '0 : (in_x[k][SAMPLE_BITS-1] ? -in_x[k] : in_x[k]);
      in_pmag[k] = in_p[k][SAMPLE_BITS-1] ? -in_p[k] : in_p[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= sample_valid;
    end
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        s1_x[k]      <= in_x[k];
        s1_pinraw[k] <= in_p[k];
        s1_sq[k]     <= in_mag[k] * in_mag[k];
        s1_prodl[k]  <= PROD_BITS'(in_mag[k] * clip_limit);
        s1_pprod[k]  <= in_pmag[k] * pin_scale;
      end
      s1_limsq <= clip_limit * clip_limit;
      s1_act   <= in_act;
      s1_pmask <= sample.pin_mask & in_act;
      s1_mode  <= per_axis_mode;
      s1_end   <= sample.end_in;
    end
  end

  always_comb begin
    logic [SQ_BITS-1:0]  sum;
    logic [PIN_BITS-1:0] m;
    sum = s1_sq[0] + s1_sq[1] + s1_sq[2];
    sq_init            = '0;
    sq_init.valid      = s1_valid;
    sq_init.v          = sum;
    sq_init.prodl      = s1_prodl;
    sq_init.side.x     = s1_x;
    sq_init.side.pmask = s1_pmask;
    sq_init.side.act   = s1_act;
    sq_init.side.mode  = s1_mode;
    sq_init.side.scale = (sum > {2'b00, s1_limsq});
    sq_init.side.end_flag = s1_end;
    for (int k = 0; k < NUM_AXES; k++) begin
      m = (s1_pprod[k] + PIN_BITS'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (s1_pinraw[k][SAMPLE_BITS-1]) begin
        if (m > PIN_BITS'(1 << (SAMPLE_BITS - 1))) begin
          m = PIN_BITS'(1 << (SAMPLE_BITS - 1));
        end
        sq_init.side.pinv[k] = -m[SAMPLE_BITS-1:0];
      end else begin
        if (m > PIN_BITS'((1 << (SAMPLE_BITS - 1)) - 1)) begin
          m = PIN_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
        end
        sq_init.side.pinv[k] = m[SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= ROOT_BITS; j++) begin
        sq_st[j].valid <= 1'b0;
      end
    end else if (en) begin
      sq_st[0] <= sq_init;
      for (int j = 1; j <= ROOT_BITS; j++) begin
        sq_st[j] <= sqrt_step(sq_st[j-1]);
      end
    end
  end

  always_comb begin
    logic [SQ_BITS-1:0] n;
    dv_init       = '0;
    dv_init.valid = sq_st[ROOT_BITS].valid;
    dv_init.side  = sq_st[ROOT_BITS].side;
    dv_init.norm  = sq_st[ROOT_BITS].root;
    for (int k = 0; k < NUM_AXES; k++) begin
      n = SQ_BITS'(sq_st[ROOT_BITS].prodl[k]) + SQ_BITS'(sq_st[ROOT_BITS].root >> 1);
      dv_init.r[k]   = n[SQ_BITS-1 -: ROOT_BITS];
      dv_init.low[k] = n[QUO_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QUO_BITS; j++) begin
        dv_st[j].valid <= 1'b0;
      end
    end else if (en) begin
      dv_st[0] <= dv_init;
      for (int j = 1; j <= QUO_BITS; j++) begin
        dv_st[j] <= div_step(dv_st[j-1]);
      end
    end
  end

  always_comb begin
    side_t                                s;
    logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS:0]          xv;
    logic signed [SAMPLE_BITS:0]          lim;
    logic                                 clipped;
    s       = dv_st[QUO_BITS].side;
    lim     = $signed({2'b00, clip_limit});
    clipped = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      xv = $signed({s.x[k][SAMPLE_BITS-1], s.x[k]});
      if (!s.act[k]) begin
        y[k] = '0;
      end else if (s.mode) begin
        if (xv > lim) begin
          y[k] = lim[SAMPLE_BITS-1:0];
        end else if (xv < -lim) begin
          y[k] = -lim[SAMPLE_BITS-1:0];
        end else begin
          y[k] = s.x[k];
        end
      end else if (s.scale) begin
        y[k] = s.x[k][SAMPLE_BITS-1] ? -dv_st[QUO_BITS].q[k] : dv_st[QUO_BITS].q[k];
      end else begin
        y[k] = s.x[k];
      end
      if (s.act[k] && (y[k] != s.x[k])) begin
        clipped = 1'b1;
      end
      if (s.pmask[k]) begin
        y[k] = s.pinv[k];
      end
    end
    res_next.result_axis0 = y[0];
    res_next.result_axis1 = y[1];
    res_next.result_axis2 = y[2];
    res_next.was_clipped  = clipped;
    res_next.end_out      = s.end_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv_st[QUO_BITS].valid;
    end
    if (en) begin
      result <= res_next;
    end
  end

endmodule

// File: rtl/gap_checker.sv
// Port-level checks of the gradient amplitude projection, bound to the top level.
module gap_checker import gap_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result,
  input logic    cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("input stalled without output backpressure");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind gradient_amplitude_projection_top gap_checker u_gap_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_ready    (cfg_ready)
);

// File: tb/gradient_amplitude_projection_top_tb.sv
// Self-checking testbench of the gradient amplitude projection: random and directed words.
module gradient_amplitude_projection_top_tb;
  import gap_pkg::*;

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  sample_t sample;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  gradient_amplitude_projection_top dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int LATENCY = 52;
  localparam int IDLE_LIMIT = 20000;

  logic [LIMIT_BITS-1:0] lim_reg;
  logic mode_reg;
  logic [1:0] count_reg;
  logic [SCALE_BITS-1:0] scale_reg;

  result_t projected_q[$];
  int mismatches;
  int idle_cycles;
  bit src_gaps;
  bit sink_gaps;
  bit hold_sink;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [47:0] int_root(logic [47:0] v);
    logic [47:0] r;
    logic [47:0] b;
    r = '0;
    b = 48'h1 << 46;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] scaled_pin(logic signed [SAMPLE_BITS-1:0] p);
    logic [63:0] m;
    logic [63:0] mp;
    mp = p < 0 ? 64'(-64'(p)) : 64'(p);
    m = (mp * 64'(scale_reg) + 64'h8000) >> 16;
    if (p < 0) begin
      if (m > 64'h800000) m = 64'h800000;
      return SAMPLE_BITS'(-m);
    end
    if (m > 64'h7FFFFF) m = 64'h7FFFFF;
    return SAMPLE_BITS'(m);
  endfunction

  function automatic result_t project(sample_t s);
    result_t o;
    logic signed [63:0] x [3];
    logic signed [63:0] y [3];
    logic signed [63:0] pv [3];
    logic signed [63:0] lim;
    logic [63:0] sum;
    logic [63:0] nrm;
    logic [63:0] q;
    logic [63:0] mg;
    int act;
    bit clipped;
    x[0] = s.sample_axis0; x[1] = s.sample_axis1; x[2] = s.sample_axis2;
    pv[0] = s.pin_axis0; pv[1] = s.pin_axis1; pv[2] = s.pin_axis2;
    lim = 64'(lim_reg);
    act = count_reg > 3 ? 3 : count_reg;
    clipped = 0;
    sum = 0;
    for (int k = 0; k < 3; k++) y[k] = 0;
    if (mode_reg) begin
      for (int k = 0; k < act; k++) begin
        y[k] = x[k];
        if (y[k] > lim) y[k] = lim;
        if (y[k] < -lim) y[k] = -lim;
      end
    end else begin
      for (int k = 0; k < act; k++) begin
        mg = x[k] < 0 ? -x[k] : x[k];
        sum += mg * mg;
      end
      if (sum > 64'(lim) * 64'(lim)) begin
        nrm = 64'(int_root(sum[47:0]));
        for (int k = 0; k < act; k++) begin
          mg = x[k] < 0 ? -x[k] : x[k];
          q = (mg * 64'(lim) + nrm / 2) / nrm;
          y[k] = x[k] < 0 ? -$signed(q) : $signed(q);
        end
      end else begin
        for (int k = 0; k < act; k++) y[k] = x[k];
      end
    end
    for (int k = 0; k < act; k++) begin
      if (y[k] != x[k]) clipped = 1;
      if (s.pin_mask[k]) y[k] = scaled_pin(pv[k][SAMPLE_BITS-1:0]);
    end
    o.result_axis0 = y[0][SAMPLE_BITS-1:0];
    o.result_axis1 = y[1][SAMPLE_BITS-1:0];
    o.result_axis2 = y[2][SAMPLE_BITS-1:0];
    o.was_clipped = clipped;
    o.end_out = s.end_in;
    return o;
  endfunction

  // drive the sample channel; valid stays up after the accept until the next call or drain
  task automatic send_word(sample_t s);
    while (src_gaps && $urandom_range(99) < 37) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    projected_q.push_back(project(s));
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CLIP_LIMIT:    lim_reg = d[LIMIT_BITS-1:0];
      CFG_PER_AXIS_MODE: mode_reg = d[0];
      CFG_AXIS_COUNT:    count_reg = d[1:0];
      default:           scale_reg = d;
    endcase
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (projected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic configure(logic [22:0] l, logic m, logic [1:0] c, logic [31:0] sc);
    drain();
    write_reg(CFG_CLIP_LIMIT, 32'(l));
    write_reg(CFG_PER_AXIS_MODE, 32'(m));
    write_reg(CFG_AXIS_COUNT, 32'(c));
    write_reg(CFG_PIN_SCALE, sc);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_axis();
    case ($urandom_range(5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(4000)) - 2000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_word();
    sample_t s;
    s.sample_axis0 = rand_axis();
    s.sample_axis1 = rand_axis();
    s.sample_axis2 = rand_axis();
    s.pin_mask = 3'($urandom);
    s.pin_axis0 = rand_axis();
    s.pin_axis1 = rand_axis();
    s.pin_axis2 = rand_axis();
    s.end_in = $urandom_range(1);
    return s;
  endfunction

  function automatic sample_t make_word(logic signed [23:0] a, logic signed [23:0] b,
                                        logic signed [23:0] c, logic [2:0] pm, logic e);
    sample_t s;
    s.sample_axis0 = a; s.sample_axis1 = b; s.sample_axis2 = c;
    s.pin_mask = pm;
    s.pin_axis0 = 24'sh7FFFFF; s.pin_axis1 = 24'sh800000; s.pin_axis2 = -24'sd3;
    s.end_in = e;
    return s;
  endfunction

  task automatic test_directed();
    send_word(make_word(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 3'b000, 1'b1));
    send_word(make_word(0, 0, 0, 3'b111, 1'b0));
    send_word(make_word(24'sh800000, 24'sh800000, 24'sh800000, 3'b101, 1'b1));
    configure(23'd65536, 1'b0, 2'd3, 32'hFFFFFFFF);
    send_word(make_word(24'sd40000, 24'sd50000, 0, 3'b000, 1'b0));
    send_word(make_word(24'sd30000, 24'sd40000, 0, 3'b010, 1'b1));
    send_word(make_word(-24'sd65536, 0, 0, 3'b111, 1'b0));
    configure(23'd1000, 1'b1, 2'd2, 32'd0);
    send_word(make_word(24'sd1001, -24'sd1001, 24'sd5000, 3'b100, 1'b0));
    send_word(make_word(24'sd1000, -24'sd1000, 24'sd5000, 3'b011, 1'b1));
    configure(23'd0, 1'b0, 2'd1, 32'd32768);
    send_word(make_word(24'sd7, 24'sd9, 24'sd9, 3'b000, 1'b0));
    send_word(make_word(0, 24'sd9, 24'sd9, 3'b001, 1'b0));
    configure(23'd0, 1'b1, 2'd0, 32'd65536);
    send_word(make_word(24'sd7, 24'sd9, 24'sd9, 3'b111, 1'b1));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        configure(23'($urandom_range(3) == 0 ? $urandom : $urandom_range(200000)),
                  $urandom_range(1), 2'($urandom), $urandom_range(1) ? $urandom
                  : $urandom_range(131072));
        src_gaps = i < 600 || i >= 800;
        sink_gaps = src_gaps;
      end
      send_word(rand_word());
    end
  endtask

  task automatic test_backpressure();
    hold_sink = 1'b1;
    for (int i = 0; i < 120; i++) send_word(rand_word());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CLIP_LIMIT;
    cfg_data = '0;
    mismatches = 0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    hold_sink = 1'b0;
    lim_reg = 23'h7FFFFF;
    mode_reg = 1'b0;
    count_reg = 2'd3;
    scale_reg = 32'd65536;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(900);
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver stall, with one long hold-off on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        result_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
        result_stall <= 1'b0;
      end else begin
        result_stall <= sink_gaps && ($urandom_range(99) < 37);
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (projected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", result);
      end else begin
        exp_r = projected_q.pop_front();
        if (result !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected %h actual %h", exp_r, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
rtl/gap_pkg.sv
rtl/gradient_amplitude_projection_top.sv
rtl/gap_checker.sv
tb/gradient_amplitude_projection_top_tb.sv
